[rtl/cbfr_pkg.sv]
package cbfr_pkg;

  localparam int unsigned LEN_BITS = 16;
  localparam logic [15:0] LEN_MAX  = 16'((32'd1 << LEN_BITS) - 32'd1);

  localparam logic [1:0] HDR_NONE   = 2'd0;
  localparam logic [1:0] HDR_LEN_HI = 2'd1;
  localparam logic [1:0] HDR_LEN_LO = 2'd2;
  localparam logic [1:0] HDR_DONE   = 2'd3;

  localparam logic [6:0] SEQ_START = 7'h00;

  localparam logic MODE_BYTE    = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic ERR_INVALID_SEQ = 1'b0;
  localparam logic ERR_SHORT_FRAME = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_offset;
    logic [6:0]  message_command;
    logic [15:0] message_length;
    logic        message_ready;
    logic        dispatched;
    logic        error_valid;
    logic        error_code;
  } out_t;

endpackage

[rtl/cbfr_in_reg.sv]
module cbfr_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cbfr_pkg::in_t in_item,
  input  logic          step,
  output logic          item_v,
  output cbfr_pkg::in_t item
);

  logic          item_v_r;
  logic          item_v_nxt;
  cbfr_pkg::in_t item_r;
  logic          take;

  assign in_ready = !item_v_r || step;
  assign take     = in_valid && in_ready;

  always_comb begin
    if (take) begin
      item_v_nxt = 1'b1;
    end else if (step) begin
      item_v_nxt = 1'b0;
    end else begin
      item_v_nxt = item_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign item_v = item_v_r;
  assign item   = item_r;

endmodule

[rtl/cbfr_core.sv]
module cbfr_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  cbfr_pkg::in_t  item,
  output cbfr_pkg::out_t res
);

  typedef struct packed {
    logic        waiting_cont;
    logic        msg_complete;
    logic [15:0] recv_offset;
    logic [15:0] msg_len;
    logic [6:0]  msg_cmd;
    logic [6:0]  next_seq;
    logic [1:0]  header_pos;
    logic        frame_is_init;
  } st_t;

  localparam st_t ST_CLEAR = '{
    waiting_cont:  1'b0,
    msg_complete:  1'b0,
    recv_offset:   16'd0,
    msg_len:       16'd0,
    msg_cmd:       7'd0,
    next_seq:      cbfr_pkg::SEQ_START,
    header_pos:    cbfr_pkg::HDR_NONE,
    frame_is_init: 1'b0
  };

  st_t         st_r;
  st_t         st_nxt;
  logic        drop_r;
  logic        drop_nxt;
  logic        err;
  logic [15:0] len_full;

  always_comb begin
    st_nxt   = st_r;
    drop_nxt = drop_r;
    res      = '0;
    err      = 1'b0;
    len_full = st_r.msg_len | {8'h00, item.data_byte};
    if (item.mode == cbfr_pkg::MODE_RELEASE) begin
      res.message_command = st_r.msg_cmd;
      res.message_length  = st_r.msg_len;
      if (st_r.msg_complete) begin
        res.dispatched = 1'b1;
        st_nxt         = ST_CLEAR;
      end
    end else begin
      if (item.first_byte) begin
        drop_nxt             = 1'b0;
        st_nxt.header_pos    = cbfr_pkg::HDR_NONE;
        st_nxt.frame_is_init = 1'b0;
        if (item.data_byte[7]) begin
          if (st_r.waiting_cont) begin
            err = 1'b1;
          end else begin
            st_nxt               = ST_CLEAR;
            st_nxt.msg_cmd       = item.data_byte[6:0];
            st_nxt.header_pos    = cbfr_pkg::HDR_LEN_HI;
            st_nxt.frame_is_init = 1'b1;
          end
        end else begin
          if (!st_r.waiting_cont || st_r.msg_complete ||
              item.data_byte[6:0] != st_r.next_seq) begin
            err = 1'b1;
          end else begin
            st_nxt.next_seq = st_r.next_seq + 7'd1;
          end
        end
        if (err) begin
          res.error_valid = 1'b1;
          res.error_code  = cbfr_pkg::ERR_INVALID_SEQ;
          st_nxt          = ST_CLEAR;
          drop_nxt        = 1'b1;
        end
      end else if (!drop_r) begin
        if (st_r.frame_is_init && st_r.header_pos == cbfr_pkg::HDR_LEN_HI) begin
          st_nxt.msg_len    = {item.data_byte, 8'h00};
          st_nxt.header_pos = cbfr_pkg::HDR_LEN_LO;
        end else if (st_r.frame_is_init && st_r.header_pos == cbfr_pkg::HDR_LEN_LO) begin
          st_nxt.msg_len      = (len_full > cbfr_pkg::LEN_MAX) ? cbfr_pkg::LEN_MAX : len_full;
          st_nxt.header_pos   = cbfr_pkg::HDR_DONE;
          st_nxt.waiting_cont = 1'b1;
          st_nxt.recv_offset  = 16'd0;
          st_nxt.next_seq     = cbfr_pkg::SEQ_START;
        end else if (st_r.waiting_cont && st_r.recv_offset < st_r.msg_len) begin
          res.payload_valid  = 1'b1;
          res.payload_byte   = item.data_byte;
          res.payload_offset = st_r.recv_offset;
          st_nxt.recv_offset = st_r.recv_offset + 16'd1;
        end
      end
      if (item.last_byte && !err && !drop_nxt) begin
        if (st_nxt.frame_is_init && (st_nxt.header_pos == cbfr_pkg::HDR_LEN_HI ||
                                     st_nxt.header_pos == cbfr_pkg::HDR_LEN_LO)) begin
          res.error_valid = 1'b1;
          res.error_code  = cbfr_pkg::ERR_SHORT_FRAME;
          st_nxt          = ST_CLEAR;
        end else if (st_nxt.waiting_cont) begin
          st_nxt.msg_complete = (st_nxt.recv_offset == st_nxt.msg_len);
          res.message_ready   = st_nxt.msg_complete;
        end
        drop_nxt = 1'b1;
      end
      res.message_command = st_nxt.msg_cmd;
      res.message_length  = st_nxt.msg_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLEAR;
      drop_r <= 1'b0;
    end else if (step) begin
      st_r   <= st_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

[rtl/cbfr_out_reg.sv]
module cbfr_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  cbfr_pkg::out_t res,
  output logic           out_valid,
  input  logic           out_ready,
  output cbfr_pkg::out_t out_item
);

  logic           out_v_r;
  logic           out_v_nxt;
  cbfr_pkg::out_t out_item_r;

  always_comb begin
    if (step) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

endmodule

[rtl/ctap_ble_frame_reassembler.sv]
// Channel   Ports                          Payload
// input     in_valid / in_ready            in_item  (cbfr_pkg::in_t)
// result    out_valid / out_ready          out_item (cbfr_pkg::out_t)
//
// One result item per input item; one item per cycle sustained while out_ready is high.
// Each accepted item is registered in the input reg, then its result in the result reg.
// All decoding and the offset/length compare sit between those two registers.
// Reset (rst_n low, synchronous) clears both stage valids and the frame state.
// A stalled result holds the result reg; the input reg then takes one more item.
module ctap_ble_frame_reassembler (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cbfr_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output cbfr_pkg::out_t out_item
);

  logic           item_v;
  cbfr_pkg::in_t  item;
  cbfr_pkg::out_t res;
  logic           step;

  assign step = item_v && (!out_valid || out_ready);

  cbfr_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .step     (step),
    .item_v   (item_v),
    .item     (item)
  );

  cbfr_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item),
    .res   (res)
  );

  cbfr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_item.message_ready, out_item.dispatched,
                              out_item.error_valid}) <= 1)
    else $error("ready, dispatch and error together");

  a_offset_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.payload_valid) |->
      (out_item.payload_offset < out_item.message_length))
    else $error("payload offset beyond message length");

  a_release_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.dispatched) |-> !out_item.payload_valid)
    else $error("payload on release item");

  a_stage_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (item_v && out_valid && !out_ready))
    else $error("input stalled without full pipeline");

endmodule

[tb/cbfr_message_check.sv]
`timescale 1ns / 100ps

module cbfr_message_check (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  cbfr_pkg::in_t  in_item,
  input  logic           out_valid,
  input  logic           out_ready,
  input  cbfr_pkg::out_t out_item,
  output int             fail_count,
  output int             pending,
  output int             results_seen,
  output int             ready_marks,
  output int             dispatch_count,
  output int             error_count
);

  cbfr_pkg::out_t predicted_out[$];
  cbfr_pkg::out_t due;

  logic        awaiting_cont;
  logic        msg_done;
  logic        in_init_frame;
  logic        skip_frame;
  logic [15:0] rx_offset;
  logic [15:0] msg_len;
  logic [6:0]  msg_cmd;
  logic [6:0]  seq_due;
  logic [1:0]  hdr_pos;

  task report(input string msg);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%t  mismatch: %s", $realtime, msg);
    end
  endtask

  task compare(input string field, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      report($sformatf("result %0d %s expected %0h got %0h", results_seen, field, want, got));
    end
  endtask

  function automatic void clear_message();
    awaiting_cont = 1'b0;
    msg_done      = 1'b0;
    rx_offset     = '0;
    msg_len       = '0;
    msg_cmd       = '0;
    seq_due       = cbfr_pkg::SEQ_START;
    hdr_pos       = cbfr_pkg::HDR_NONE;
    in_init_frame = 1'b0;
  endfunction

  function automatic cbfr_pkg::out_t reassemble(input cbfr_pkg::in_t it);
    cbfr_pkg::out_t r;
    logic           bad;
    logic [15:0]    len;
    r   = '0;
    bad = 1'b0;
    if (it.mode == cbfr_pkg::MODE_RELEASE) begin
      r.message_command = msg_cmd;
      r.message_length  = msg_len;
      if (msg_done) begin
        r.dispatched = 1'b1;
        clear_message();
      end
    end else begin
      if (it.first_byte) begin
        skip_frame    = 1'b0;
        hdr_pos       = cbfr_pkg::HDR_NONE;
        in_init_frame = 1'b0;
        if (it.data_byte[7]) begin
          if (awaiting_cont) begin
            bad = 1'b1;
          end else begin
            clear_message();
            msg_cmd       = it.data_byte[6:0];
            hdr_pos       = cbfr_pkg::HDR_LEN_HI;
            in_init_frame = 1'b1;
          end
        end else if (!awaiting_cont || msg_done || it.data_byte[6:0] != seq_due) begin
          bad = 1'b1;
        end else begin
          seq_due = seq_due + 7'd1;
        end
        if (bad) begin
          r.error_valid = 1'b1;
          r.error_code  = cbfr_pkg::ERR_INVALID_SEQ;
          clear_message();
          skip_frame = 1'b1;
        end
      end else if (!skip_frame) begin
        if (in_init_frame && hdr_pos == cbfr_pkg::HDR_LEN_HI) begin
          msg_len = {it.data_byte, 8'h00};
          hdr_pos = cbfr_pkg::HDR_LEN_LO;
        end else if (in_init_frame && hdr_pos == cbfr_pkg::HDR_LEN_LO) begin
          len = msg_len | {8'h00, it.data_byte};
          if (len > cbfr_pkg::LEN_MAX) begin
            len = cbfr_pkg::LEN_MAX;
          end
          msg_len       = len;
          hdr_pos       = cbfr_pkg::HDR_DONE;
          awaiting_cont = 1'b1;
          rx_offset     = '0;
          seq_due       = cbfr_pkg::SEQ_START;
        end else if (awaiting_cont && rx_offset < msg_len) begin
          r.payload_valid  = 1'b1;
          r.payload_byte   = it.data_byte;
          r.payload_offset = rx_offset;
          rx_offset        = rx_offset + 16'd1;
        end
      end
      if (it.last_byte && !bad && !skip_frame) begin
        if (in_init_frame && (hdr_pos == cbfr_pkg::HDR_LEN_HI ||
                              hdr_pos == cbfr_pkg::HDR_LEN_LO)) begin
          r.error_valid = 1'b1;
          r.error_code  = cbfr_pkg::ERR_SHORT_FRAME;
          clear_message();
        end else if (awaiting_cont) begin
          msg_done        = (rx_offset == msg_len);
          r.message_ready = msg_done;
        end
        skip_frame = 1'b1;
      end
      r.message_command = msg_cmd;
      r.message_length  = msg_len;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_message();
      skip_frame = 1'b0;
      predicted_out.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_out.size() == 0) begin
          report("result with no item outstanding");
        end else begin
          due = predicted_out.pop_front();
          compare("payload_valid", 16'(due.payload_valid), 16'(out_item.payload_valid));
          compare("payload_byte", 16'(due.payload_byte), 16'(out_item.payload_byte));
          compare("payload_offset", due.payload_offset, out_item.payload_offset);
          compare("message_command", 16'(due.message_command), 16'(out_item.message_command));
          compare("message_length", due.message_length, out_item.message_length);
          compare("message_ready", 16'(due.message_ready), 16'(out_item.message_ready));
          compare("dispatched", 16'(due.dispatched), 16'(out_item.dispatched));
          compare("error_valid", 16'(due.error_valid), 16'(out_item.error_valid));
          compare("error_code", 16'(due.error_code), 16'(out_item.error_code));
          results_seen++;
          if (due.message_ready) ready_marks++;
          if (due.dispatched) dispatch_count++;
          if (due.error_valid) error_count++;
        end
      end
      if (in_valid && in_ready) begin
        predicted_out.push_back(reassemble(in_item));
      end
      pending <= predicted_out.size();
    end
  end

endmodule

[tb/ctap_ble_frame_reassembler_test.sv]
`timescale 1ns / 100ps

module ctap_ble_frame_reassembler_test;

  localparam int IDLE_LIMIT  = 2000;
  localparam int ITEM_TARGET = 1950;

  logic           clk;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           out_ready = 1'b0;
  cbfr_pkg::in_t  in_item   = '0;
  logic           in_ready;
  logic           out_valid;
  cbfr_pkg::out_t out_item;

  int fail_count, pending, results_seen, ready_marks, dispatch_count, error_count;
  int items_sent;
  int messages_sent;
  int burst_left;
  int idle_cycles;
  int rx_mode;
  int rx_phase_left;
  int rx_hold_left;
  logic rx_hold_val = 1'b0;

  ctap_ble_frame_reassembler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  cbfr_message_check i_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .ready_marks    (ready_marks),
    .dispatch_count (dispatch_count),
    .error_count    (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: phases of always-ready, random ready and alternating held-ready / held-stall runs
  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_phase_left = $urandom_range(50, 400);
      rx_mode       = $urandom_range(0, 2);
    end else begin
      rx_phase_left--;
    end
    case (rx_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        if (rx_hold_left == 0) begin
          rx_hold_left = $urandom_range(1, 15);
          rx_hold_val  = ~rx_hold_val;
        end else begin
          rx_hold_left--;
        end
        out_ready <= rx_hold_val;
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic cbfr_pkg::in_t frame_byte(input logic [7:0] b, input logic f,
                                                input logic l);
    cbfr_pkg::in_t it;
    it.mode       = cbfr_pkg::MODE_BYTE;
    it.data_byte  = b;
    it.first_byte = f;
    it.last_byte  = l;
    return it;
  endfunction

  function automatic cbfr_pkg::in_t release_item();
    cbfr_pkg::in_t it;
    it.mode       = cbfr_pkg::MODE_RELEASE;
    it.data_byte  = 8'($urandom);
    it.first_byte = 1'($urandom);
    it.last_byte  = 1'($urandom);
    return it;
  endfunction

  function automatic cbfr_pkg::in_t noise_item();
    cbfr_pkg::in_t it;
    it = cbfr_pkg::in_t'($urandom);
    return it;
  endfunction

  task automatic send(input cbfr_pkg::in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // stop_after: continuation frames to send before giving up (-1 = all)
  // bad_frame: continuation frame that carries a wrong sequence number (-1 = none)
  task automatic send_message(input logic [6:0] cmd, input logic [15:0] len, input int fsize,
                              input int pad, input int stop_after, input int bad_frame);
    int remaining;
    int chunk;
    int frame_no;
    int i;
    logic [6:0] seq;
    logic [6:0] tag;
    messages_sent++;
    remaining = int'(len) + pad;
    chunk = (fsize > 3) ? fsize - 3 : 0;
    if (chunk > remaining) chunk = remaining;
    send(frame_byte({1'b1, cmd}, 1'b1, 1'b0));
    send(frame_byte(len[15:8], 1'b0, 1'b0));
    send(frame_byte(len[7:0], 1'b0, chunk == 0));
    for (i = 0; i < chunk; i++) begin
      send(frame_byte(8'($urandom), 1'b0, i == chunk - 1));
    end
    remaining -= chunk;
    seq = cbfr_pkg::SEQ_START;
    frame_no = 0;
    while (remaining > 0 && frame_no != stop_after) begin
      chunk = fsize - 1;
      if (chunk > remaining) chunk = remaining;
      tag = (frame_no == bad_frame) ? seq + 7'($urandom_range(1, 127)) : seq;
      send(frame_byte({1'b0, tag}, 1'b1, 1'b0));
      for (i = 0; i < chunk; i++) begin
        send(frame_byte(8'($urandom), 1'b0, i == chunk - 1));
      end
      if (frame_no == bad_frame) return;
      remaining -= chunk;
      seq = seq + 7'd1;
      frame_no++;
    end
  endtask

  initial begin
    int pick;
    int n;
    int i;
    logic [6:0] cmd;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    send(frame_byte(8'hFF, 1'b0, 1'b0));
    send(release_item());
    send_message(7'h7F, 16'h0000, 3, 0, -1, -1);
    send(release_item());
    send_message(7'h00, 16'h0002, 4, 1, -1, -1);
    send(frame_byte(8'h01, 1'b1, 1'b1));
    send(frame_byte(8'h85, 1'b1, 1'b0));
    send(frame_byte(8'h12, 1'b0, 1'b1));
    send(frame_byte(8'h81, 1'b1, 1'b0));
    send(frame_byte(8'h00, 1'b1, 1'b1));
    send(frame_byte(8'h81, 1'b1, 1'b0));
    send_message(7'h02, 16'h0005, 3, 0, 0, -1);
    send(frame_byte(8'h03, 1'b1, 1'b1));
    send_message(7'h40, 16'hFFFF, 3, 0, 0, -1);
    send(frame_byte(8'h80, 1'b1, 1'b1));
    send(frame_byte(8'h00, 1'b1, 1'b1));
    send(frame_byte(8'hAA, 1'b0, 1'b1));

    // long chain of tiny frames so the sequence number wraps
    send_message(7'($urandom), 16'($urandom_range(130, 150)), 2, 0, -1, -1);
    send(release_item());

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      cmd  = 7'($urandom);
      if (pick < 62) begin
        n = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 40) : $urandom_range(41, 300);
        send_message(cmd, 16'(n), $urandom_range(2, 20),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0, -1, -1);
        if ($urandom_range(0, 9) != 0) send(release_item());
      end else if (pick < 68) begin
        send_message(cmd, 16'($urandom_range(20, 60)), $urandom_range(2, 8), 0,
                     $urandom_range(0, 3), -1);
        if ($urandom_range(0, 1) == 0) send(release_item());
      end else if (pick < 73) begin
        send_message(cmd, 16'($urandom_range(10, 60)), $urandom_range(2, 8), 0, -1,
                     $urandom_range(0, 3));
      end else if (pick < 76) begin
        send_message(cmd, 16'($urandom_range(16'hFF00, 16'hFFFF)), $urandom_range(2, 20), 0,
                     $urandom_range(1, 3), -1);
      end else if (pick < 80) begin
        n = $urandom_range(1, 2);
        send(frame_byte({1'b1, cmd}, 1'b1, n == 1));
        if (n == 2) send(frame_byte(8'($urandom), 1'b0, 1'b1));
      end else if (pick < 83) begin
        send(frame_byte({1'b1, cmd}, 1'b1, 1'b0));
        if ($urandom_range(0, 1) == 0) send(frame_byte(8'($urandom), 1'b0, 1'b0));
      end else if (pick < 87) begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) begin
          send(frame_byte(i == 0 ? {1'b0, 7'($urandom)} : 8'($urandom), i == 0, i == n - 1));
        end
      end else if (pick < 90) begin
        send(release_item());
      end else if (pick < 94) begin
        send_message(cmd, 16'($urandom_range(0, 10)), $urandom_range(2, 12), 0, -1, -1);
        send(frame_byte({1'b0, 7'($urandom)}, 1'b1, 1'b1));
        send(release_item());
      end else begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
          send(noise_item());
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d items carrying %0d messages; %0d results checked",
             items_sent, messages_sent, results_seen);
    $display("Messages completed %0d, dispatched %0d, error responses %0d",
             ready_marks, dispatch_count, error_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
rtl/cbfr_pkg.sv
rtl/cbfr_in_reg.sv
rtl/cbfr_core.sv
rtl/cbfr_out_reg.sv
rtl/ctap_ble_frame_reassembler.sv
tb/cbfr_message_check.sv
tb/ctap_ble_frame_reassembler_test.sv
